[rtl/pdes_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdes_pkg
// Shared types and constants of the active/expired priority run queue.
// ----------------------------------------------------------------------------
package pdes_pkg;

    localparam int MAX_PRIO_DEF    = 4;
    localparam int LEVEL_DEPTH_DEF = 16;

    localparam int ID_W    = 8;
    localparam int SP_W    = 3;
    localparam int DP_W    = 2;
    localparam int SLICE_W = 16;

    localparam logic [SLICE_W-1:0] QUANTUM_RST = 16'd2;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [SP_W-1:0] sprio;
    } t_entry;

    typedef struct packed {
        logic issue;
        logic load;
    } t_cmd;

endpackage

[rtl/pdes_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdes_ctrl
// Sequencer: issues one request to the datapath, then loads the result into
// the output register once that register is free.
// ----------------------------------------------------------------------------
module pdes_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pdes_pkg::t_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RD   = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_issue;
    logic w_load;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_issue     = i_in_valid && (r_state == ST_IDLE);
    assign o_cmd.issue = w_issue;
    assign o_cmd.load  = w_load;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        w_load      = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_issue) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/pdes_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdes_datapath
// Level pointers and counts, entry memory, bank select and result register.
// ----------------------------------------------------------------------------
module pdes_datapath #(
    parameter int MAX_PRIO    = pdes_pkg::MAX_PRIO_DEF,
    parameter int LEVEL_DEPTH = pdes_pkg::LEVEL_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pdes_pkg::t_cmd                i_cmd,
    input  logic                          i_cfg_we,
    input  logic [pdes_pkg::SLICE_W-1:0]  i_cfg_data,
    input  logic                          i_mode,
    input  logic [pdes_pkg::ID_W-1:0]     i_proc_id,
    input  logic [pdes_pkg::SP_W-1:0]     i_static_prio,
    input  logic [pdes_pkg::DP_W-1:0]     i_dyn_prio,
    output logic                          o_op_ok,
    output logic [pdes_pkg::ID_W-1:0]     o_out_id,
    output logic [pdes_pkg::DP_W-1:0]     o_out_dyn_prio,
    output logic [pdes_pkg::SP_W-1:0]     o_out_static_prio,
    output logic [pdes_pkg::SLICE_W-1:0]  o_out_slice,
    output logic                          o_went_expired,
    output logic                          o_all_empty
);

    localparam int NUM_LEVELS = 2 * MAX_PRIO;
    localparam int LW  = (MAX_PRIO > 1) ? $clog2(MAX_PRIO) : 1;
    localparam int LIW = $clog2(NUM_LEVELS);
    localparam int PW  = $clog2(LEVEL_DEPTH);
    localparam int CW  = $clog2(LEVEL_DEPTH + 1);

    localparam logic [4:0]     MAX_LVL  = 5'(MAX_PRIO - 1);
    localparam logic [PW-1:0]  LAST_PTR = PW'(LEVEL_DEPTH - 1);
    localparam logic [CW-1:0]  FULL_CNT = CW'(LEVEL_DEPTH);
    localparam logic [LIW-1:0] BANK_OFS = LIW'(MAX_PRIO);

    pdes_pkg::t_entry r_mem [NUM_LEVELS][LEVEL_DEPTH];

    logic [PW-1:0]  r_head [NUM_LEVELS];
    logic [PW-1:0]  r_tail [NUM_LEVELS];
    logic [CW-1:0]  r_cnt  [NUM_LEVELS];
    logic           r_bank;
    logic [pdes_pkg::SLICE_W-1:0] r_quantum;

    pdes_pkg::t_entry r_rd;
    logic             r_mode;
    logic             r_ok;
    logic [pdes_pkg::DP_W-1:0] r_odyn;
    logic             r_oexp;

    logic                          r_op_ok;
    logic [pdes_pkg::ID_W-1:0]     r_out_id;
    logic [pdes_pkg::DP_W-1:0]     r_out_dyn;
    logic [pdes_pkg::SP_W-1:0]     r_out_sp;
    logic [pdes_pkg::SLICE_W-1:0]  r_out_slice;
    logic                          r_went_exp;
    logic                          r_all_empty;

    logic [MAX_PRIO-1:0] w_ne0;
    logic [MAX_PRIO-1:0] w_ne1;
    logic                w_act;
    logic [MAX_PRIO-1:0] w_ne_act;
    logic                w_found;
    logic [LW-1:0]       w_dq_lvl;
    logic                w_expired;
    logic [4:0]          w_raw;
    logic [LW-1:0]       w_eq_lvl;
    logic                w_eq_bank;
    logic                w_deq;
    logic [LW-1:0]       w_lvl;
    logic                w_bank;
    logic [LIW-1:0]      w_li;
    logic                w_full;
    logic                w_do_wr;
    logic                w_do_rd;

    always_comb begin
        for (int l = 0; l < MAX_PRIO; l++) begin
            w_ne0[l] = (r_cnt[l] != '0);
            w_ne1[l] = (r_cnt[l + MAX_PRIO] != '0);
        end
    end

    // bank swap when the active set is empty
    assign w_act    = ((r_bank ? w_ne1 : w_ne0) == '0) ? ~r_bank : r_bank;
    assign w_ne_act = w_act ? w_ne1 : w_ne0;

    always_comb begin
        w_found  = 1'b0;
        w_dq_lvl = '0;
        for (int l = 0; l < MAX_PRIO; l++) begin
            if (w_ne_act[l]) begin
                w_found  = 1'b1;
                w_dq_lvl = LW'(l);
            end
        end
    end

    always_comb begin
        w_expired = (i_dyn_prio == '0);
        if (w_expired) begin
            w_raw = (i_static_prio == '0) ? 5'd0 : (5'(i_static_prio) - 5'd1);
        end else begin
            w_raw = 5'(i_dyn_prio) - 5'd1;
        end
        if (w_raw > MAX_LVL) begin
            w_raw = MAX_LVL;
        end
        w_eq_lvl  = w_raw[LW-1:0];
        w_eq_bank = w_expired ? ~r_bank : r_bank;
    end

    assign w_deq   = (i_mode == pdes_pkg::MODE_DEQ);
    assign w_lvl   = w_deq ? w_dq_lvl : w_eq_lvl;
    assign w_bank  = w_deq ? w_act : w_eq_bank;
    assign w_li    = (w_bank ? BANK_OFS : '0) + LIW'(w_lvl);
    assign w_full  = (r_cnt[w_li] == FULL_CNT);
    assign w_do_wr = i_cmd.issue && !w_deq && !w_full;
    assign w_do_rd = i_cmd.issue && w_deq && w_found;

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[w_li][r_tail[w_li]] <= '{id: i_proc_id, sprio: i_static_prio};
        end
        if (w_do_rd) begin
            r_rd <= r_mem[w_li][r_head[w_li]];
        end
    end

    // level bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_cnt[k]  <= '0;
            end
            r_bank    <= 1'b0;
            r_quantum <= pdes_pkg::QUANTUM_RST;
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_data;
            end
            if (i_cmd.issue && w_deq) begin
                r_bank <= w_act;
            end
            if (w_do_wr) begin
                r_tail[w_li] <= (r_tail[w_li] == LAST_PTR) ? '0 : r_tail[w_li] + 1'b1;
                r_cnt[w_li]  <= r_cnt[w_li] + 1'b1;
            end
            if (w_do_rd) begin
                r_head[w_li] <= (r_head[w_li] == LAST_PTR) ? '0 : r_head[w_li] + 1'b1;
                r_cnt[w_li]  <= r_cnt[w_li] - 1'b1;
            end
        end
    end

    // request stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_mode <= i_mode;
            r_ok   <= w_deq ? w_found : !w_full;
            r_oexp <= !w_deq && !w_full && w_expired;
            if (w_deq) begin
                r_odyn <= w_found ? pdes_pkg::DP_W'(5'(w_dq_lvl)) : '0;
            end else begin
                r_odyn <= w_raw[pdes_pkg::DP_W-1:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op_ok     <= r_ok;
            r_out_id    <= (r_mode == pdes_pkg::MODE_DEQ && r_ok) ? r_rd.id : '0;
            r_out_sp    <= (r_mode == pdes_pkg::MODE_DEQ && r_ok) ? r_rd.sprio : '0;
            r_out_dyn   <= r_odyn;
            r_out_slice <= r_ok ? r_quantum : '0;
            r_went_exp  <= r_oexp;
            r_all_empty <= (w_ne0 == '0) && (w_ne1 == '0);
        end
    end

    assign o_op_ok           = r_op_ok;
    assign o_out_id          = r_out_id;
    assign o_out_dyn_prio    = r_out_dyn;
    assign o_out_static_prio = r_out_sp;
    assign o_out_slice       = r_out_slice;
    assign o_went_expired    = r_went_exp;
    assign o_all_empty       = r_all_empty;

endmodule

[rtl/priority_decay_expired_scheduler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_decay_expired_scheduler_unit
// Active/expired priority run queue with enqueue and dequeue requests.
// ----------------------------------------------------------------------------
// A request first updates the per-level head, tail and count registers and
// accesses the entry memory; its result is then formed from the registered
// memory read data. A new request is not taken until the last result has been
// loaded into the output register; the block holds off input in the cycle after each
// accepted request, and for as long after that as a finished result waits
// behind a stalled output register. No clearing pass is needed after reset.
// time_quantum is written through i_cfg_we; the user must write it only while
// no request is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module priority_decay_expired_scheduler_unit #(
    parameter int MAX_PRIO    = pdes_pkg::MAX_PRIO_DEF,
    parameter int LEVEL_DEPTH = pdes_pkg::LEVEL_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pdes_pkg::SLICE_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [pdes_pkg::ID_W-1:0]     i_proc_id,
    input  logic [pdes_pkg::SP_W-1:0]     i_static_prio,
    input  logic [pdes_pkg::DP_W-1:0]     i_dyn_prio,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_op_ok,
    output logic [pdes_pkg::ID_W-1:0]     o_out_id,
    output logic [pdes_pkg::DP_W-1:0]     o_out_dyn_prio,
    output logic [pdes_pkg::SP_W-1:0]     o_out_static_prio,
    output logic [pdes_pkg::SLICE_W-1:0]  o_out_slice,
    output logic                          o_went_expired,
    output logic                          o_all_empty
);

    pdes_pkg::t_cmd w_cmd;

    pdes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    pdes_datapath #(
        .MAX_PRIO    (MAX_PRIO),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_mode),
        .i_proc_id         (i_proc_id),
        .i_static_prio     (i_static_prio),
        .i_dyn_prio        (i_dyn_prio),
        .o_op_ok           (o_op_ok),
        .o_out_id          (o_out_id),
        .o_out_dyn_prio    (o_out_dyn_prio),
        .o_out_static_prio (o_out_static_prio),
        .o_out_slice       (o_out_slice),
        .o_went_expired    (o_went_expired),
        .o_all_empty       (o_all_empty)
    );

endmodule
